@@ rtl/core/priority_ready_queue_unit_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef PRIORITY_READY_QUEUE_UNIT_MACROS_SVH
`define PRIORITY_READY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define PRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, gated by reset.
`define PRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/prq_pkg.sv @@
package prq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PRIO_LEVELS = 64;
	localparam int ID_W        = 16;
	localparam int PRIO_W      = 6;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_POP    = 2'd1,
		MODE_CHECK  = 2'd2
	} prq_mode_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_POP    = 2'd2
	} prq_cell_op_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ID_W-1:0]   thread_id;
		logic [PRIO_W-1:0] thread_priority;
		logic [PRIO_W-1:0] running_priority;
	} prq_req_t;

	typedef struct packed {
		logic              got_entry;
		logic [ID_W-1:0]   popped_id;
		logic [PRIO_W-1:0] popped_priority;
		logic              preempt;
		logic              dropped;
		logic [CNT_W-1:0]  entry_count;
	} prq_rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} prq_entry_t;

	typedef struct packed {
		prq_cell_op_t op;
		prq_entry_t   ins;
	} prq_cell_ctl_t;

	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
		logic [PRIO_W:0] limit;
		limit = (PRIO_W + 1)'(PRIO_LEVELS - 1);
		if ({1'b0, p} > limit) begin
			return limit[PRIO_W-1:0];
		end
		return p;
	endfunction

endpackage

@@ rtl/core/prq_cell.sv @@
module prq_cell import prq_pkg::*; (
	input  logic          clk,
	input  prq_cell_ctl_t ctl,
	input  logic          occ,
	input  logic          left_keep,
	input  prq_entry_t    left_ent,
	input  prq_entry_t    right_ent,
	output logic          keep,
	output prq_entry_t    ent
);

	prq_entry_t ent_q;

	assign ent  = ent_q;
	assign keep = occ && (ent_q.prio >= ctl.ins.prio);

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (!keep) begin
					ent_q <= left_keep ? ctl.ins : left_ent;
				end
			end
			CELL_POP: begin
				ent_q <= right_ent;
			end
			default: begin
				ent_q <= ent_q;
			end
		endcase
	end

endmodule

@@ rtl/core/priority_ready_queue_unit.sv @@
// Result: the strobe on done rises in the cycle after a request is accepted.
// Throughput: one request per cycle; busy stays low, every cell of the sorted
// chain compares and shifts in the same cycle.
// Reset: arst_n clears the entry count and the result strobe; slot contents
// stay undefined until written. done cannot be held off by the receiver.
module priority_ready_queue_unit import prq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  prq_req_t req,
	output logic     done,
	output prq_rsp_t rsp
);

	logic [CNT_W-1:0]   count_q;
	logic               done_q;
	prq_rsp_t           rsp_q;

	logic               accept;
	logic               full;
	logic               do_ins;
	logic               do_pop;
	logic               drop;
	logic [PRIO_W-1:0]  ins_prio;
	logic [PRIO_W-1:0]  run_prio;
	logic [PRIO_W-1:0]  front_nxt;
	logic [CNT_W-1:0]   count_nxt;
	prq_cell_ctl_t      ctl;
	prq_entry_t         ents [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] keeps;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign ins_prio = clamp_prio(req.thread_priority);
	assign run_prio = clamp_prio(req.running_priority);
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		do_ins = 1'b0;
		do_pop = 1'b0;
		drop   = 1'b0;
		unique case (req.mode)
			MODE_INSERT: begin
				do_ins = accept && !full;
				drop   = accept && full;
			end
			MODE_POP: begin
				do_pop = accept && (count_q != '0);
			end
			default: begin
				do_ins = 1'b0;
			end
		endcase
	end

	always_comb begin
		ctl.ins.id   = req.thread_id;
		ctl.ins.prio = ins_prio;
		if (do_ins) begin
			ctl.op = CELL_INSERT;
		end else if (do_pop) begin
			ctl.op = CELL_POP;
		end else begin
			ctl.op = CELL_HOLD;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic       occ;
		logic       lk;
		prq_entry_t le;
		prq_entry_t re;

		assign occ = (count_q > CNT_W'(i));

		if (i == 0) begin : g_first
			assign lk = 1'b1;
			assign le = ctl.ins;
		end else begin : g_mid
			assign lk = keeps[i-1];
			assign le = ents[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign re = ents[i];
		end else begin : g_inner
			assign re = ents[i+1];
		end

		prq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ),
			.left_keep (lk),
			.left_ent  (le),
			.right_ent (re),
			.keep      (keeps[i]),
			.ent       (ents[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		front_nxt = ents[0].prio;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
			if ((count_q == '0) || (ins_prio > ents[0].prio)) begin
				front_nxt = ins_prio;
			end
		end else if (do_pop) begin
			count_nxt = count_q - CNT_W'(1);
			front_nxt = ents[1].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.got_entry       <= do_pop;
			rsp_q.popped_id       <= do_pop ? ents[0].id : '0;
			rsp_q.popped_priority <= do_pop ? ents[0].prio : '0;
			rsp_q.preempt         <= (count_nxt != '0) && (front_nxt > run_prio);
			rsp_q.dropped         <= drop;
			rsp_q.entry_count     <= count_nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ rtl/core/prq_checker.sv @@
`include "priority_ready_queue_unit_macros.svh"

module prq_checker import prq_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done,
	input prq_rsp_t rsp
);

	`PRQ_ASSERT_NEXT(a_done_after_req, start && !busy, done, "request without result")
	`PRQ_ASSERT_NEXT(a_no_spurious_done, !(start && !busy), !done, "result without request")
	`PRQ_ASSERT_NOW(a_drop_when_full, done && rsp.dropped,
		rsp.entry_count == CNT_W'(QUEUE_DEPTH) && !rsp.got_entry, "drop with room left")
	`PRQ_ASSERT_NOW(a_idle_pop_zero, done && !rsp.got_entry,
		rsp.popped_id == '0 && rsp.popped_priority == '0, "idle result carries an entry")

endmodule

bind priority_ready_queue_unit prq_checker u_prq_checker (.*);
